FILE: rtl/skvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Shared constants, transaction types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_GET   = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_ERASE = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_SIZE  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [63:0] key;
        logic [31:0]        value;
    } skvt_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      value_out;
        logic [CNT_W-1:0] count;
    } skvt_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_DECIDE,
        S_SHIFT,
        S_INSERT
    } skvt_state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_MID,
        RD_SHIFT
    } skvt_rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_NEW,
        WR_VAL
    } skvt_wr_sel_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } skvt_cnt_op_t;

    typedef struct packed {
        logic         load;
        logic         compare;
        logic         shift_init;
        logic         shift_step;
        skvt_rd_sel_t rd_sel;
        skvt_wr_sel_t wr_sel;
        logic         finish;
        logic [1:0]   status;
        logic         value_en;
        skvt_cnt_op_t cnt_op;
    } skvt_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       search_open;
        logic       hit;
        logic       full;
        logic       shift_more;
    } skvt_stat_t;

endpackage

FILE: rtl/skvt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table datapath
// Entry memories, search bounds, shift pointer, entry count and result register.
// ----------------------------------------------------------------------------
module skvt_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  skvt_pkg::skvt_req_t req,
    input  skvt_pkg::skvt_cmd_t cmd,
    output skvt_pkg::skvt_stat_t stat,
    output logic                done,
    output skvt_pkg::skvt_rsp_t rsp
);

    logic [63:0] key_mem [skvt_pkg::CAPACITY];
    logic [31:0] val_mem [skvt_pkg::CAPACITY];

    skvt_pkg::skvt_req_t          req_reg;
    logic [skvt_pkg::CNT_W-1:0]   lo_reg;
    logic [skvt_pkg::CNT_W-1:0]   hi_reg;
    logic [skvt_pkg::CNT_W-1:0]   mid_reg;
    logic [skvt_pkg::CNT_W-1:0]   ptr_reg;
    logic [skvt_pkg::CNT_W-1:0]   pend_addr_reg;
    logic [skvt_pkg::CNT_W-1:0]   cnt_reg;
    logic                         hit_reg;
    logic                         pend_reg;
    logic                         done_reg;
    skvt_pkg::skvt_rsp_t          rsp_reg;
    logic [63:0]                  key_rd_reg;
    logic [31:0]                  val_rd_reg;

    logic [skvt_pkg::CNT_W-1:0]   mid;
    logic [skvt_pkg::CNT_W-1:0]   cnt_next;
    logic [skvt_pkg::CNT_W-1:0]   rd_addr;
    logic [skvt_pkg::CNT_W-1:0]   wr_addr;
    logic                         rd_en;
    logic                         wr_key_en;
    logic                         wr_val_en;
    logic [63:0]                  wr_key;
    logic [31:0]                  wr_val;
    logic                         is_add;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign is_add = (req_reg.opcode == skvt_pkg::OP_ADD);

    assign stat.op          = req_reg.opcode;
    assign stat.hit         = hit_reg;
    assign stat.full        = (cnt_reg == skvt_pkg::CNT_W'(skvt_pkg::CAPACITY));
    assign stat.search_open = (req_reg.opcode inside {skvt_pkg::OP_ADD, skvt_pkg::OP_GET,
                                                      skvt_pkg::OP_SET, skvt_pkg::OP_ERASE})
                              && (lo_reg < hi_reg) && !hit_reg;
    assign stat.shift_more  = is_add ? (ptr_reg > lo_reg) : (ptr_reg < cnt_reg);

    always_comb
    begin
        case (cmd.cnt_op)
            skvt_pkg::CNT_INC: cnt_next = cnt_reg + 1'b1;
            skvt_pkg::CNT_DEC: cnt_next = cnt_reg - 1'b1;
            skvt_pkg::CNT_CLR: cnt_next = '0;
            default:           cnt_next = cnt_reg;
        endcase
    end

    // Insert moves entries up, reading below the pointer; erase moves them down.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = mid;
        case (cmd.rd_sel)
            skvt_pkg::RD_MID:
            begin
                rd_en   = 1'b1;
                rd_addr = mid;
            end
            skvt_pkg::RD_SHIFT:
            begin
                rd_en   = 1'b1;
                rd_addr = is_add ? (ptr_reg - 1'b1) : ptr_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_addr   = lo_reg;
        wr_key    = key_rd_reg;
        wr_val    = val_rd_reg;
        case (cmd.wr_sel)
            skvt_pkg::WR_SHIFT:
            begin
                wr_key_en = pend_reg;
                wr_val_en = pend_reg;
                wr_addr   = pend_addr_reg;
            end
            skvt_pkg::WR_NEW:
            begin
                wr_key_en = 1'b1;
                wr_val_en = 1'b1;
                wr_key    = req_reg.key;
                wr_val    = req_reg.value;
            end
            skvt_pkg::WR_VAL:
            begin
                wr_val_en = 1'b1;
                wr_val    = req_reg.value;
            end
            default:
            begin
                wr_key_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_key_en)
        begin
            key_mem[wr_addr[skvt_pkg::IDX_W-1:0]] <= wr_key;
        end
        if (wr_val_en)
        begin
            val_mem[wr_addr[skvt_pkg::IDX_W-1:0]] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr[skvt_pkg::IDX_W-1:0]];
            val_rd_reg <= val_mem[rd_addr[skvt_pkg::IDX_W-1:0]];
        end
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.finish)
        begin
            rsp_reg.status    <= cmd.status;
            rsp_reg.value_out <= cmd.value_en ? val_rd_reg : 32'd0;
            rsp_reg.count     <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            ptr_reg       <= '0;
            pend_addr_reg <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            pend_reg <= (cmd.rd_sel == skvt_pkg::RD_SHIFT);
            if (cmd.rd_sel == skvt_pkg::RD_MID)
            begin
                mid_reg <= mid;
            end
            if (cmd.rd_sel == skvt_pkg::RD_SHIFT)
            begin
                pend_addr_reg <= is_add ? ptr_reg : (ptr_reg - 1'b1);
            end
            if (cmd.load)
            begin
                lo_reg  <= '0;
                hi_reg  <= cnt_reg;
                hit_reg <= 1'b0;
            end
            else if (cmd.compare)
            begin
                // A hit collapses the bounds onto the matching entry.
                if (key_rd_reg == req_reg.key)
                begin
                    hit_reg <= 1'b1;
                    lo_reg  <= mid_reg;
                    hi_reg  <= mid_reg;
                end
                else if ($signed(req_reg.key) < $signed(key_rd_reg))
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg + 1'b1;
                end
            end
            if (cmd.shift_init)
            begin
                ptr_reg <= is_add ? cnt_reg : (lo_reg + 1'b1);
            end
            else if (cmd.shift_step)
            begin
                ptr_reg <= is_add ? (ptr_reg - 1'b1) : (ptr_reg + 1'b1);
            end
            if (cmd.finish)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: rtl/skvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table controller
// Sequences search probes, entry shifts and result issue for one transaction.
// ----------------------------------------------------------------------------
module skvt_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  skvt_pkg::skvt_stat_t stat,
    output logic                 busy,
    output skvt_pkg::skvt_cmd_t  cmd
);

    skvt_pkg::skvt_state_t state_reg;
    skvt_pkg::skvt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skvt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = skvt_pkg::RD_NONE;
        cmd.wr_sel     = skvt_pkg::WR_NONE;
        cmd.cnt_op     = skvt_pkg::CNT_KEEP;
        cmd.status     = skvt_pkg::ST_OK;
        case (state_reg)
            skvt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = skvt_pkg::S_SEARCH;
                end
            end
            skvt_pkg::S_SEARCH:
            begin
                if (stat.search_open)
                begin
                    cmd.rd_sel = skvt_pkg::RD_MID;
                    state_next = skvt_pkg::S_CMP;
                end
                else
                begin
                    state_next = skvt_pkg::S_DECIDE;
                end
            end
            skvt_pkg::S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = skvt_pkg::S_SEARCH;
            end
            skvt_pkg::S_DECIDE:
            begin
                state_next = skvt_pkg::S_IDLE;
                case (stat.op)
                    skvt_pkg::OP_ADD:
                    begin
                        if (stat.hit)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = skvt_pkg::ST_DUP;
                        end
                        else if (stat.full)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = skvt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = skvt_pkg::S_SHIFT;
                        end
                    end
                    skvt_pkg::OP_GET:
                    begin
                        cmd.finish   = 1'b1;
                        cmd.value_en = stat.hit;
                        cmd.status   = stat.hit ? skvt_pkg::ST_OK : skvt_pkg::ST_MISSING;
                    end
                    skvt_pkg::OP_SET:
                    begin
                        cmd.finish = 1'b1;
                        cmd.wr_sel = stat.hit ? skvt_pkg::WR_VAL : skvt_pkg::WR_NONE;
                        cmd.status = stat.hit ? skvt_pkg::ST_OK : skvt_pkg::ST_MISSING;
                    end
                    skvt_pkg::OP_ERASE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = skvt_pkg::S_SHIFT;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = skvt_pkg::ST_MISSING;
                        end
                    end
                    skvt_pkg::OP_CLEAR:
                    begin
                        cmd.finish = 1'b1;
                        cmd.cnt_op = skvt_pkg::CNT_CLR;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                    end
                endcase
            end
            skvt_pkg::S_SHIFT:
            begin
                // Each cycle reads one entry and writes the one read before it.
                cmd.wr_sel = skvt_pkg::WR_SHIFT;
                if (stat.shift_more)
                begin
                    cmd.rd_sel     = skvt_pkg::RD_SHIFT;
                    cmd.shift_step = 1'b1;
                end
                else if (stat.op == skvt_pkg::OP_ADD)
                begin
                    state_next = skvt_pkg::S_INSERT;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.cnt_op = skvt_pkg::CNT_DEC;
                    state_next = skvt_pkg::S_IDLE;
                end
            end
            skvt_pkg::S_INSERT:
            begin
                cmd.wr_sel = skvt_pkg::WR_NEW;
                cmd.finish = 1'b1;
                cmd.cnt_op = skvt_pkg::CNT_INC;
                state_next = skvt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = skvt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != skvt_pkg::S_IDLE);

endmodule

FILE: rtl/sorted_key_value_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table unit
// Up to 64 signed-key/value pairs kept in key order, searched by bisection.
// ----------------------------------------------------------------------------
// A request transaction is taken at a rising edge with start high and busy
// low; req carries the opcode, key and value. Exactly one result follows on
// rsp, valid for the single cycle in which done is high. The receiver cannot
// stall the unit, so results must be sampled when done is seen.
// Each search probe is a registered read of the entry memory, then a compare;
// a lookup makes up to 7 probes. Add and erase then move the later entries
// one per cycle through the single read and write port of the memory. busy
// stays high from acceptance until the cycle in which done rises, and a new
// request may be given in that cycle.
// Reset empties the table at once; the entry memories hold no reset value and
// are only read below the current count.
// ----------------------------------------------------------------------------
module sorted_key_value_table_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  skvt_pkg::skvt_req_t req,
    output logic                done,
    output skvt_pkg::skvt_rsp_t rsp
);

    skvt_pkg::skvt_cmd_t  cmd;
    skvt_pkg::skvt_stat_t stat;

    skvt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    skvt_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

FILE: bench/tb_sorted_key_value_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table unit testbench
// Drives add, get, set, erase, clear, size and unused opcodes through the
// start/busy handshake. Each response is checked against a shadow table that
// is kept sorted by signed key.
// ----------------------------------------------------------------------------
module tb_sorted_key_value_table_unit;

    localparam logic [2:0] OP_RSVD6    = 3'd6;
    localparam logic [2:0] OP_RSVD7    = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam int         END_DRAIN   = 100;
    localparam int         POOL_MAX    = 100;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    skvt_pkg::skvt_req_t req       = '0;
    logic                busy;
    logic                done;
    skvt_pkg::skvt_rsp_t rsp;

    logic      req_taken = 1'b0;
    int        sender_idle_pct = 0;
    int        idle_cycles     = 0;
    int        fail_count      = 0;

    skvt_pkg::skvt_req_t req_backlog[$];
    skvt_pkg::skvt_rsp_t rsp_expected[$];
    logic signed [63:0]  shadow_keys[$];
    logic [31:0]         shadow_vals[$];
    logic signed [63:0]  key_pool[$];

    sorted_key_value_table_unit DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one request to the shadow table and returns the response it
    // should produce.
    function automatic skvt_pkg::skvt_rsp_t predict_table_op(skvt_pkg::skvt_req_t r);
        skvt_pkg::skvt_rsp_t result;
        logic signed [63:0]  k;
        int                  slot;
        bit                  hit;
        result = '0;
        result.status = skvt_pkg::ST_OK;
        k = r.key;
        slot = 0;
        while (slot < shadow_keys.size() && shadow_keys[slot] < k)
            slot++;
        hit = (slot < shadow_keys.size()) && (shadow_keys[slot] == k);
        case (r.opcode)
            skvt_pkg::OP_ADD:
            begin
                if (hit)
                    result.status = skvt_pkg::ST_DUP;
                else if (shadow_keys.size() >= skvt_pkg::CAPACITY)
                    result.status = skvt_pkg::ST_FULL;
                else
                begin
                    shadow_keys.insert(slot, k);
                    shadow_vals.insert(slot, r.value);
                end
            end
            skvt_pkg::OP_GET:
            begin
                if (hit)
                    result.value_out = shadow_vals[slot];
                else
                    result.status = skvt_pkg::ST_MISSING;
            end
            skvt_pkg::OP_SET:
            begin
                if (hit)
                    shadow_vals[slot] = r.value;
                else
                    result.status = skvt_pkg::ST_MISSING;
            end
            skvt_pkg::OP_ERASE:
            begin
                if (hit)
                begin
                    shadow_keys.delete(slot);
                    shadow_vals.delete(slot);
                end
                else
                    result.status = skvt_pkg::ST_MISSING;
            end
            skvt_pkg::OP_CLEAR:
            begin
                shadow_keys.delete();
                shadow_vals.delete();
            end
            default: ;
        endcase
        result.count = skvt_pkg::CNT_W'(shadow_keys.size());
        return result;
    endfunction

    task automatic push_req(logic [2:0] op, logic signed [63:0] k, logic [31:0] v);
        skvt_pkg::skvt_req_t r;
        r.opcode = op;
        r.key    = k;
        r.value  = v;
        req_backlog.push_back(r);
    endtask

    // Full-width keys half of the time, the rest clustered near zero and near both
    // ends of the signed range so that ordering across the sign is exercised.
    function automatic logic signed [63:0] fresh_key();
        logic signed [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: k = {1'b1, 63'd0} + 64'($urandom_range(0, 3));
            1: k = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
            2, 3: k = 64'($urandom_range(0, 63)) - 64'd32;
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [63:0] known_or_fresh_key(int hit_pct);
        if (key_pool.size() != 0 && $urandom_range(0, 99) < hit_pct)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return fresh_key();
    endfunction

    task automatic remember_key(logic signed [63:0] k);
        key_pool.push_back(k);
        if (key_pool.size() > POOL_MAX)
            void'(key_pool.pop_front());
    endtask

    // A phase opens with a clear and a burst of adds that runs the table past
    // full, then mixes all operations; gets, sets and erases mostly reuse known keys.
    task automatic queue_phase(int n_mixed);
        logic signed [63:0] k;
        int                 pick;
        push_req(skvt_pkg::OP_CLEAR, fresh_key(), random_value());
        repeat (70)
        begin
            k = {$urandom, $urandom};
            remember_key(k);
            push_req(skvt_pkg::OP_ADD, k, random_value());
        end
        repeat (n_mixed)
        begin
            pick = $urandom_range(0, 999);
            if (pick < 420)
            begin
                k = known_or_fresh_key(25);
                remember_key(k);
                push_req(skvt_pkg::OP_ADD, k, random_value());
            end
            else if (pick < 600)
                push_req(skvt_pkg::OP_GET, known_or_fresh_key(70), random_value());
            else if (pick < 720)
                push_req(skvt_pkg::OP_SET, known_or_fresh_key(70), random_value());
            else if (pick < 870)
                push_req(skvt_pkg::OP_ERASE, known_or_fresh_key(70), random_value());
            else if (pick < 873)
                push_req(skvt_pkg::OP_CLEAR, fresh_key(), random_value());
            else if (pick < 930)
                push_req(skvt_pkg::OP_SIZE, fresh_key(), random_value());
            else
                push_req(($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6,
                         fresh_key(), random_value());
        end
    endtask

    task automatic drain_backlog();
        while (req_backlog.size() != 0 || start)
            @(posedge clk);
    endtask

    // A new transaction is offered once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                req   <= req_backlog.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        skvt_pkg::skvt_rsp_t oldest;
        if (rst_n)
        begin
            // A response seen in the same cycle as an acceptance belongs to
            // the earlier transaction, so it is checked first.
            if (done)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $error("response with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest = rsp_expected.pop_front();
                    if (rsp.status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.value_out !== oldest.value_out)
                    begin
                        $error("value_out: expected %h, got %h",
                               oldest.value_out, rsp.value_out);
                        fail_count++;
                    end
                    if (rsp.count !== oldest.count)
                    begin
                        $error("count: expected %0d, got %0d", oldest.count, rsp.count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                rsp_expected.push_back(predict_table_op(req));
            req_taken <= start && !busy;
            idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("** sorted_key_value_table_unit: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 24;
        push_req(skvt_pkg::OP_SIZE, 64'sd0, 32'd0);
        push_req(skvt_pkg::OP_GET, 64'sd0, 32'd0);
        push_req(skvt_pkg::OP_SET, 64'sd5, 32'h1234_5678);
        push_req(skvt_pkg::OP_ERASE, -64'sd1, 32'd0);
        push_req(skvt_pkg::OP_ADD, {1'b0, {63{1'b1}}}, 32'hFFFF_FFFF);
        push_req(skvt_pkg::OP_ADD, {1'b1, 63'd0}, 32'd0);
        push_req(skvt_pkg::OP_ADD, 64'sd0, 32'h1234_5678);
        push_req(skvt_pkg::OP_ADD, -64'sd1, 32'hA5A5_A5A5);
        push_req(skvt_pkg::OP_ADD, 64'sd1, 32'h5A5A_5A5A);
        push_req(skvt_pkg::OP_ADD, {1'b1, 63'd0}, 32'hDEAD_BEEF);
        push_req(skvt_pkg::OP_GET, {1'b1, 63'd0}, 32'd0);
        push_req(skvt_pkg::OP_GET, {1'b0, {63{1'b1}}}, 32'd0);
        push_req(skvt_pkg::OP_GET, 64'sd1, 32'd0);
        push_req(skvt_pkg::OP_SET, -64'sd1, 32'hFFFF_FFFF);
        push_req(skvt_pkg::OP_GET, -64'sd1, 32'd0);
        push_req(skvt_pkg::OP_GET, 64'sd2, 32'd0);
        push_req(skvt_pkg::OP_ERASE, 64'sd0, 32'd0);
        push_req(skvt_pkg::OP_ERASE, {1'b1, 63'd0}, 32'd0);
        push_req(skvt_pkg::OP_ERASE, {1'b0, {63{1'b1}}}, 32'd0);
        push_req(skvt_pkg::OP_GET, 64'sd1, 32'd0);
        push_req(OP_RSVD6, {1'b0, {63{1'b1}}}, 32'hFFFF_FFFF);
        push_req(OP_RSVD7, {1'b1, 63'd0}, 32'hFFFF_FFFF);
        push_req(skvt_pkg::OP_CLEAR, 64'sd1, 32'd0);
        push_req(skvt_pkg::OP_SIZE, -64'sd1, 32'd0);
        push_req(skvt_pkg::OP_GET, -64'sd1, 32'd0);
        queue_phase(520);
        drain_backlog();

        sender_idle_pct = 68;
        queue_phase(520);
        drain_backlog();

        sender_idle_pct = 0;
        queue_phase(520);
        drain_backlog();

        while (rsp_expected.size() != 0)
            @(posedge clk);
        repeat (END_DRAIN) @(posedge clk);

        if (rsp_expected.size() != 0)
        begin
            $error("%0d responses never arrived", rsp_expected.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** sorted_key_value_table_unit: PASSED **");
        else
            $display("** sorted_key_value_table_unit: FAILED **");
        $finish;
    end

endmodule
